// File: src/ljpf_pkg.sv
// Shared types and codes for the Lennard-Jones pair force update block.
// Used by the front, back and top modules; depends on nothing else.
`default_nettype none
package ljpf_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  localparam logic [2:0] REG_EPSILON     = 3'd0;
  localparam logic [2:0] REG_SIGMA_POW6  = 3'd1;
  localparam logic [2:0] REG_SIGMA_POW12 = 3'd2;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd3;
  localparam logic [2:0] REG_PIN         = 3'd4;
  localparam logic [2:0] REG_CHAIN_LEN   = 3'd5;
  localparam logic [2:0] REG_FORCE_LIMIT = 3'd6;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_PAIR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [31:0] epsilon;
    logic [31:0] sigma_pow6;
    logic [31:0] sigma_pow12;
    logic [31:0] step_size;
    logic [31:0] force_limit;
    logic        pin_endpoints;
    logic [10:0] chain_length;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  status;
    logic [10:0] index_a;
    logic [10:0] index_b;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        move_a;
    logic        move_b;
  } desc_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
  } res_t;

endpackage
`default_nettype wire

// File: src/ljpf_queue.sv
// Small first-in first-out queue of packed words.
// Used between the front and back parts and at the result side; no dependencies.
`default_nettype none
module ljpf_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;
  logic do_push, do_pop;

  assign full = cnt == (PW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - (PW+1)'(1);
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ljpf_front.sv
// Front part: accepts items, decodes and checks them, and queues a descriptor.
// Depends on ljpf_pkg and ljpf_queue.
`default_nettype none
module ljpf_front import ljpf_pkg::*; #(
  parameter int PARTICLES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cfg_t             cfg,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [10:0] index_a,
  input  wire logic [10:0] index_b,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [31:0] in_z,
  input  wire logic        q_pop,
  output desc_t            q_dout,
  output logic             q_empty
);
  desc_t dsc;
  logic a_ok, b_ok;
  logic [12:0] n13;

  function automatic logic pinned(input logic [10:0] idx, input logic [12:0] n);
    logic [12:0] i;
    i = {2'b00, idx};
    return i == 13'd0 || i == n - 13'd1 || i == n || i == (n << 1) - 13'd1;
  endfunction

  assign n13 = {2'b00, cfg.chain_length};
  assign a_ok = {21'b0, index_a} < 32'(PARTICLES);
  assign b_ok = {21'b0, index_b} < 32'(PARTICLES);

  always_comb begin
    dsc.op = OP_NOP;
    dsc.status = ST_DONE;
    dsc.index_a = index_a;
    dsc.index_b = index_b;
    dsc.x = in_x;
    dsc.y = in_y;
    dsc.z = in_z;
    dsc.move_a = !(cfg.pin_endpoints && pinned(index_a, n13));
    dsc.move_b = !(cfg.pin_endpoints && pinned(index_b, n13));
    case (cmd)
      CMD_WRITE: begin
        if (a_ok) dsc.op = OP_WRITE;
      end
      CMD_READ: begin
        if (a_ok) dsc.op = OP_READ;
      end
      CMD_PAIR: begin
        if (index_b <= index_a || !a_ok || !b_ok) begin
          dsc.status = ST_ORDER;
        end else begin
          dsc.op = OP_PAIR;
        end
      end
      default: dsc.op = OP_NOP;
    endcase
  end

  ljpf_queue #(.W($bits(desc_t)), .DEPTH(2)) u_q (
    .clk(clk), .rst(rst), .push(push), .din(dsc), .full(full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );
endmodule
`default_nettype wire

// File: src/ljpf_mul.sv
// Shared 64 by 64 bit unsigned multiplier, one 32 by 32 partial product a cycle.
// No dependencies; the full 128-bit product is valid when done pulses.
`default_nettype none
module ljpf_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [127:0]     p
);
  logic [63:0] ra, rb;
  logic [63:0] pp;
  logic [1:0] sh;
  logic [2:0] cnt;
  logic busy;
  logic [31:0] ha, hb;

  assign ha = cnt[1] ? ra[63:32] : ra[31:0];
  assign hb = cnt[0] ? rb[63:32] : rb[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
      p <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp <= ha * hb;
        sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      end
      if (cnt != 3'd0) begin
        p <= p + ({64'b0, pp} << (7'd32 * {5'b0, sh}));
      end
    end
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 3'd4;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ljpf_div.sv
// Restoring unsigned divider, 64-bit quotient, one bit a cycle.
// No dependencies; quotient is valid when done pulses.
`default_nettype none
module ljpf_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic [64:0] rem, rem_sh;
  logic [63:0] d;
  logic [6:0] cnt;
  logic busy, qbit;

  assign rem_sh = {rem[63:0], quo[63]};
  assign qbit = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      d <= den;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? rem_sh - {1'b0, d} : rem_sh;
      quo <= {quo[62:0], qbit};
    end
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == 7'd1;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/ljpf_back.sv
// Back part: position store and the sequencer that carries out each descriptor.
// Depends on ljpf_pkg, ljpf_mul and ljpf_div.
`default_nettype none
module ljpf_back import ljpf_pkg::*; #(
  parameter int PARTICLES = 2048,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  desc_t     q_dout,
  input  wire logic q_empty,
  output logic      q_pop,
  output res_t      res_din,
  output logic      res_push,
  input  wire logic res_full
);
  localparam int AW = $clog2(PARTICLES);
  localparam int IW = (AW > 11) ? AW : 11;
  localparam logic [63:0] SAT = '1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDA   = 13'b0000000000010,
    S_RDB   = 13'b0000000000100,
    S_DIFF  = 13'b0000000001000,
    S_SQ    = 13'b0000000010000,
    S_R2    = 13'b0000000100000,
    S_DIV   = 13'b0000001000000,
    S_CHAIN = 13'b0000010000000,
    S_FK    = 13'b0000100000000,
    S_DK    = 13'b0001000000000,
    S_WRA   = 13'b0010000000000,
    S_WRB   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state;
  desc_t d;
  logic [31:0] mem_x [PARTICLES];
  logic [31:0] mem_y [PARTICLES];
  logic [31:0] mem_z [PARTICLES];
  logic [31:0] rd [3];
  logic [31:0] pa [3];
  logic [31:0] pb [3];
  logic [31:0] ad [3];
  logic dneg [3];
  logic [31:0] res [3];
  logic [63:0] m [3];
  logic [31:0] na [3];
  logic [31:0] nb [3];
  logic [31:0] wd [3];
  logic [65:0] acc;
  logic [63:0] u, u2, u3, u4, t, mag, gmag;
  logic gneg, sat, mwait;
  logic [1:0] stat;
  logic [2:0] k;
  logic [1:0] kk;
  logic [63:0] ma, mb, mop_a, mop_b, mq, r2raw, r2, dq, e24, fk_q, fm;
  logic [127:0] mp;
  logic mstart, mdone, dstart, ddone, we, fk_sat;
  logic [31:0] fk_val;
  logic [AW-1:0] raddr, waddr;
  logic [IW-1:0] ea, eb;

  function automatic logic [63:0] rshr(input logic [63:0] p);
    return (p >> FRAC_BITS) + {63'b0, p[FRAC_BITS-1]};
  endfunction

  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b,
                                       input logic [127:0] p);
    logic [128:0] s;
    s = ({1'b0, p} + (129'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (a == '0 || b == '0) return '0;
    if (a == SAT || b == SAT) return SAT;
    if (|s[128:64]) return SAT;
    return s[63:0];
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -66'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  assign ea = IW'(d.index_a);
  assign eb = IW'(d.index_b);
  assign kk = k[1:0];
  assign raddr = (state == S_RDB) ? eb[AW-1:0] : ea[AW-1:0];
  assign waddr = (state == S_WRB) ? eb[AW-1:0] : ea[AW-1:0];
  assign q_pop = state == S_IDLE && !q_empty;
  assign res_push = state == S_OUT && !res_full;
  assign res_din = '{x: res[0], y: res[1], z: res[2], status: stat};

  assign e24 = ({32'b0, cfg.epsilon} << 4) + ({32'b0, cfg.epsilon} << 3);
  assign r2raw = (|acc[65:64]) ? SAT : acc[63:0];
  assign r2 = rshr(r2raw);
  assign dstart = state == S_R2 && r2raw != '0 && r2 != '0;
  assign mq = mulq(ma, mb, mp);

  assign mstart = !mwait && (state == S_SQ || state == S_CHAIN || state == S_FK ||
                             state == S_DK);

  always_comb begin
    fm = {32'b0, res[kk][31] ? ~res[kk] + 32'd1 : res[kk]};
    mop_a = '0;
    mop_b = '0;
    case (state)
      S_SQ: begin
        mop_a = {32'b0, ad[kk]};
        mop_b = {32'b0, ad[kk]};
      end
      S_CHAIN: begin
        case (k)
          3'd0: begin mop_a = u; mop_b = u; end
          3'd1: begin mop_a = u2; mop_b = u; end
          3'd2: begin mop_a = u2; mop_b = u2; end
          3'd3: begin mop_a = {32'b0, cfg.sigma_pow12}; mop_b = u3; end
          3'd4: begin mop_a = e24; mop_b = u4; end
          default: begin mop_a = t; mop_b = gmag; end
        endcase
      end
      S_FK: begin
        mop_a = mag;
        mop_b = {32'b0, ad[kk]};
      end
      S_DK: begin
        mop_a = {32'b0, cfg.step_size};
        mop_b = fm;
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
  end

  always_comb begin
    logic sneg;
    sneg = gneg ^ dneg[kk];
    fk_q = rshr(mp[63:0]);
    fk_sat = 1'b0;
    if (!sneg) begin
      if (fk_q > 64'h7FFFFFFF) begin
        fk_sat = 1'b1;
        fk_val = 32'h7FFFFFFF;
      end else begin
        fk_val = fk_q[31:0];
      end
    end else begin
      if (fk_q > 64'h80000000) begin
        fk_sat = 1'b1;
        fk_val = 32'h80000000;
      end else begin
        fk_val = ~fk_q[31:0] + 32'd1;
      end
    end
  end

  always_comb begin
    logic signed [65:0] dl;
    for (int i = 0; i < 3; i++) begin
      dl = res[i][31] ? -$signed({2'b00, m[i]}) : $signed({2'b00, m[i]});
      na[i] = clamp32($signed({{34{pa[i][31]}}, pa[i]}) + dl);
      nb[i] = clamp32($signed({{34{pb[i][31]}}, pb[i]}) - dl);
    end
  end

  always_comb begin
    if (state == S_WRB) begin
      wd = nb;
      we = d.move_b;
    end else if (d.op == OP_WRITE) begin
      wd[0] = d.x;
      wd[1] = d.y;
      wd[2] = d.z;
      we = state == S_WRA;
    end else begin
      wd = na;
      we = state == S_WRA && d.move_a;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wd[0];
      mem_y[waddr] <= wd[1];
      mem_z[waddr] <= wd[2];
    end
    rd[0] <= mem_x[raddr];
    rd[1] <= mem_y[raddr];
    rd[2] <= mem_z[raddr];
  end

  ljpf_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(mop_a), .b(mop_b), .done(mdone), .p(mp)
  );

  ljpf_div u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num((64'd1 << (2 * FRAC_BITS)) + (r2 >> 1)), .den(r2), .done(ddone), .quo(dq)
  );

  always_ff @(posedge clk) begin
    logic [32:0] df;
    logic [63:0] rep;
    if (mstart) begin
      ma <= mop_a;
      mb <= mop_b;
    end
    if (rst) begin
      state <= S_IDLE;
      mwait <= 1'b0;
      k <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            d <= q_dout;
            stat <= q_dout.status;
            sat <= 1'b0;
            for (int i = 0; i < 3; i++) res[i] <= '0;
            case (q_dout.op)
              OP_WRITE: state <= S_WRA;
              OP_READ, OP_PAIR: state <= S_RDA;
              default: state <= S_OUT;
            endcase
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          pa <= rd;
          if (d.op == OP_READ) begin
            res <= rd;
            state <= S_OUT;
          end else begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          pb <= rd;
          for (int i = 0; i < 3; i++) begin
            df = {pa[i][31], pa[i]} - {rd[i][31], rd[i]};
            dneg[i] <= df[32];
            ad[i] <= df[32] ? ~df[31:0] + 32'd1 : df[31:0];
          end
          acc <= '0;
          k <= '0;
          mwait <= 1'b0;
          state <= S_SQ;
        end
        S_SQ, S_CHAIN, S_FK, S_DK: begin
          if (!mwait) begin
            mwait <= 1'b1;
          end else if (mdone) begin
            mwait <= 1'b0;
            case (state)
              S_SQ: begin
                acc <= acc + {2'b00, mp[63:0]};
                k <= k + 3'd1;
                if (k == 3'd2) state <= S_R2;
              end
              S_CHAIN: begin
                k <= (k >= 3'd5) ? 3'd0 : k + 3'd1;
                case (k)
                  3'd0: u2 <= mq;
                  3'd1: u3 <= mq;
                  3'd2: u4 <= mq;
                  3'd3: begin
                    rep = mq[63] ? SAT : {mq[62:0], 1'b0};
                    if (rep >= {32'b0, cfg.sigma_pow6}) begin
                      gneg <= 1'b0;
                      gmag <= (rep == SAT) ? SAT : rep - {32'b0, cfg.sigma_pow6};
                    end else begin
                      gneg <= 1'b1;
                      gmag <= {32'b0, cfg.sigma_pow6} - rep;
                    end
                  end
                  3'd4: t <= mq;
                  default: begin
                    if (mq > {32'b0, cfg.force_limit}) begin
                      mag <= {32'b0, cfg.force_limit};
                      sat <= 1'b1;
                    end else begin
                      mag <= mq;
                    end
                    state <= S_FK;
                  end
                endcase
              end
              S_FK: begin
                res[kk] <= fk_val;
                if (fk_sat) sat <= 1'b1;
                k <= (k == 3'd2) ? 3'd0 : k + 3'd1;
                if (k == 3'd2) state <= S_DK;
              end
              default: begin
                m[kk] <= rshr(mp[63:0]);
                k <= k + 3'd1;
                if (k == 3'd2) state <= S_WRA;
              end
            endcase
          end
        end
        S_R2: begin
          k <= '0;
          mwait <= 1'b0;
          if (r2raw == '0) begin
            stat <= ST_ZERO;
            state <= S_OUT;
          end else if (r2 == '0) begin
            u <= SAT;
            state <= S_CHAIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            u <= dq;
            state <= S_CHAIN;
          end
        end
        S_WRA: state <= (d.op == OP_WRITE) ? S_OUT : S_WRB;
        S_WRB: begin
          stat <= sat ? ST_SAT : ST_DONE;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/lj_pair_force_update_core.sv
// Top level of the Lennard-Jones pair force update block.
// Depends on ljpf_pkg, ljpf_front, ljpf_back and ljpf_queue.
//
// Items enter on a queue-like port: an item is taken at a clock edge with push
// high and full low. Results leave the same way: the oldest result sits on
// out_x, out_y, out_z and status while empty is low and is taken on pop.
// Registers are written over the cfg port (cfg_ready is always high), by the user
// only while no item is in flight; the block itself does not enforce it.
// Every item gives one result, in order. A pair item's time is set by the
// divider for the reciprocal and by fifteen passes through the shared
// multiplier; a zero-distance pair skips the divider and the later passes.
// One item is worked on at a time; two more wait in the input queue and two
// results in the output queue.
// When the receiver stalls, the output queue fills, the back part holds its
// finished result and the input queue then fills and raises full.
// Reset empties both queues, returns the sequencer to idle and loads the
// register defaults. The position store is not cleared: an entry must be
// written before it is read.
`default_nettype none
module lj_pair_force_update_core import ljpf_pkg::*; #(
  parameter int PARTICLES = 2048,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [10:0] index_a,
  input  wire logic [10:0] index_b,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [31:0] in_z,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  cfg_t cfg;
  desc_t q_dout;
  logic q_empty, q_pop, res_push, res_full;
  res_t res_din, res_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.epsilon <= 32'd65536;
      cfg.sigma_pow6 <= 32'd65536;
      cfg.sigma_pow12 <= 32'd65536;
      cfg.step_size <= 32'd655;
      cfg.pin_endpoints <= 1'b1;
      cfg.chain_length <= 11'd1024;
      cfg.force_limit <= 32'd19660800;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EPSILON: cfg.epsilon <= cfg_data;
        REG_SIGMA_POW6: cfg.sigma_pow6 <= cfg_data;
        REG_SIGMA_POW12: cfg.sigma_pow12 <= cfg_data;
        REG_STEP_SIZE: cfg.step_size <= cfg_data;
        REG_PIN: cfg.pin_endpoints <= cfg_data[0];
        REG_CHAIN_LEN: cfg.chain_length <= cfg_data[10:0];
        REG_FORCE_LIMIT: cfg.force_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  ljpf_front #(.PARTICLES(PARTICLES)) u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .push(push), .full(full), .cmd(cmd),
    .index_a(index_a), .index_b(index_b), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .q_pop(q_pop), .q_dout(q_dout), .q_empty(q_empty)
  );

  ljpf_back #(.PARTICLES(PARTICLES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_dout(q_dout), .q_empty(q_empty),
    .q_pop(q_pop), .res_din(res_din), .res_push(res_push), .res_full(res_full)
  );

  ljpf_queue #(.W($bits(res_t)), .DEPTH(2)) u_outq (
    .clk(clk), .rst(rst), .push(res_push), .din(res_din), .full(res_full),
    .pop(pop), .dout(res_dout), .empty(empty)
  );

  assign out_x = res_dout.x;
  assign out_y = res_dout.y;
  assign out_z = res_dout.z;
  assign status = res_dout.status;
endmodule
`default_nettype wire
